/* rtl/rgb_color_decorrelate_filter_defines.svh */
// Assertion macros for the green-difference color filter.
`ifndef RGB_COLOR_DECORRELATE_FILTER_DEFINES_SVH
`define RGB_COLOR_DECORRELATE_FILTER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RCD_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rgb_color_decorrelate_filter: assertion failed");

// Next-cycle implication, checked outside reset.
`define RCD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rgb_color_decorrelate_filter: assertion failed");

`endif

/* rtl/rcd_pkg.sv */
// Shared types and constants of the green-difference color filter.
`timescale 1ns / 1ps

package rcd_pkg;

    localparam int RCD_QDEPTH = 6;

    localparam logic       MODE_ENC = 1'b0;
    localparam logic       MODE_DEC = 1'b1;

    localparam logic [1:0] CFG_MODE    = 2'd0;
    localparam logic [1:0] CFG_ROW     = 2'd1;
    localparam logic [1:0] CFG_MIN_RUN = 2'd2;

    localparam logic [1:0] PH_FIRST  = 2'd0;
    localparam logic [1:0] PH_SECOND = 2'd1;
    localparam logic [1:0] PH_THIRD  = 2'd2;

    localparam logic [15:0] ROW_RESET     = 16'd3;
    localparam logic [15:0] MIN_RUN_RESET = 16'd63;
    localparam logic [15:0] RUN_SAT       = 16'hFFFF;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_res;

    typedef struct packed {
        logic [1:0]     num;
        t_res [2:0]     ent;
    } t_push;

endpackage

/* rtl/rcd_outq.sv */
// Result queue: takes up to three words per cycle, hands out one.
`timescale 1ns / 1ps

module rcd_outq #(
    parameter int DEPTH = rcd_pkg::RCD_QDEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  rcd_pkg::t_push             i_push,
    input  logic                       i_pop,
    output rcd_pkg::t_res              o_head,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);
    import rcd_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    t_res [DEPTH-1:0] r_mem;
    t_res [DEPTH-1:0] n_mem;
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    n_count;
    logic [CW-1:0]    base;

    always_comb begin
        n_mem = r_mem;
        base  = r_count;
        if (i_pop) begin
            for (int i = 0; i < DEPTH - 1; i++) begin
                n_mem[i] = r_mem[i+1];
            end
            base = r_count - CW'(1);
        end
        for (int i = 0; i < DEPTH; i++) begin
            for (int j = 0; j < 3; j++) begin
                if ((2'(j) < i_push.num) && (CW'(i) == base + CW'(j))) begin
                    n_mem[i] = i_push.ent[j];
                end
            end
        end
        n_count = base + CW'(i_push.num);
    end

    always_ff @(posedge i_clk) begin
        r_mem <= n_mem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_head  = r_mem[0];
    assign o_count = r_count;

endmodule

/* rtl/rgb_color_decorrelate_filter.sv */
// Top level of the green-difference color filter for 24-bit bitmap rows.
`timescale 1ns / 1ps
`include "rgb_color_decorrelate_filter_defines.svh"

// Takes one image byte per cycle and turns each b,g,r pixel into g, g-r, g-b (encode)
// or back (decode); padding bytes at the row end pass through. Each input word is
// handled in the cycle it is accepted and its results (none, one or three words)
// land in a result queue of DEPTH words. Input is taken whenever the queue has room
// for three words, so with DEPTH of 6 or more the block sustains one input word per
// cycle while the output side takes a word every cycle; the queue drain of one word
// per cycle is what sets the average rate. last_of_run marks the final word of an
// input's results. Configuration writes take effect at once and belong to idle time.
module rgb_color_decorrelate_filter #(
    parameter int DEPTH = rcd_pkg::RCD_QDEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_start_of_image,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_last_of_run
);
    import rcd_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    function automatic logic [7:0] fix3(input logic [7:0] v);
        fix3 = {v[7:3], v[2:0] ^ {3{v[3]}}};
    endfunction

    function automatic logic [7:0] fix2(input logic [7:0] v);
        fix2 = {v[7:2], v[1:0] ^ {2{v[2]}}};
    endfunction

    function automatic logic looks565(input logic [7:0] b, input logic [7:0] g,
                                      input logic [7:0] r);
        looks565 = (b[2:0] == {3{b[3]}}) && (g[1:0] == {2{g[2]}})
                && (r[2:0] == {3{r[3]}});
    endfunction

    logic        r_mode;
    logic [15:0] r_row_bytes;
    logic [15:0] r_min_run;
    logic [15:0] r_pos;
    logic [1:0]  r_phase;
    logic [7:0]  r_h1;
    logic [7:0]  r_h2;
    logic [15:0] r_run;
    logic        r_det;

    logic [15:0] n_pos;
    logic [1:0]  n_phase;
    logic [7:0]  n_h1;
    logic [7:0]  n_h2;
    logic [15:0] n_run;
    logic        n_det;

    logic        acc;
    logic [15:0] pos_e;
    logic [1:0]  ph_e;
    logic [7:0]  h1_e;
    logic [7:0]  h2_e;
    logic [15:0] run_e;
    logic        det_e;
    logic        in_pix;
    logic        pix3;
    logic [16:0] nxt;
    logic [15:0] run_inc;

    logic [7:0]  eb, eg, er;
    logic [15:0] enc_run;
    logic        enc_corr;
    logic [7:0]  dg, dr, db;
    logic [7:0]  cb, cg, cr;
    logic [15:0] dec_run;

    t_push       push;
    logic        pop;
    t_res        head;
    logic [CW-1:0] q_count;

    assign acc    = i_in_valid && o_in_ready;
    assign pos_e  = i_start_of_image ? '0 : r_pos;
    assign ph_e   = i_start_of_image ? PH_FIRST : r_phase;
    assign h1_e   = i_start_of_image ? '0 : r_h1;
    assign h2_e   = i_start_of_image ? '0 : r_h2;
    assign run_e  = i_start_of_image ? '0 : r_run;
    assign det_e  = i_start_of_image ? 1'b1 : r_det;

    // pixel whose group of three fits in the row
    assign in_pix = (17'(pos_e) + 17'(2'd3 - ph_e)) <= 17'(r_row_bytes);
    assign pix3   = in_pix && (ph_e == PH_THIRD);
    assign nxt    = 17'(pos_e) + 17'd1;
    assign run_inc = (run_e == RUN_SAT) ? run_e : run_e + 16'd1;

    always_comb begin
        eb       = h1_e;
        eg       = h2_e;
        er       = i_in_byte;
        enc_run  = looks565(eb, eg, er) ? run_inc : '0;
        enc_corr = det_e && ((enc_run > r_min_run) || (run_e >= r_min_run));
        if (enc_corr) begin
            eb = fix3(eb);
            eg = fix2(eg);
            er = fix3(er);
        end
    end

    always_comb begin
        dg = h1_e;
        dr = h1_e - h2_e;
        db = h1_e - i_in_byte;
        cb = db;
        cg = dg;
        cr = dr;
        if (det_e && (run_e >= r_min_run)) begin
            cb = fix3(db);
            cg = fix2(dg);
            cr = fix3(dr);
        end
        dec_run = looks565(cb, cg, cr) ? run_inc : '0;
    end

    always_comb begin
        n_pos   = r_pos;
        n_phase = r_phase;
        n_h1    = r_h1;
        n_h2    = r_h2;
        n_run   = r_run;
        n_det   = r_det;
        push    = '0;
        if (acc) begin
            n_h1  = h1_e;
            n_h2  = h2_e;
            n_run = run_e;
            n_det = det_e;
            if (nxt >= 17'(r_row_bytes)) begin
                n_pos   = '0;
                n_phase = PH_FIRST;
            end else begin
                n_pos   = nxt[15:0];
                n_phase = (ph_e == PH_THIRD) ? PH_FIRST : ph_e + 2'd1;
            end
            if (!in_pix) begin
                push.num         = 2'd1;
                push.ent[0].data = i_in_byte;
                push.ent[0].last = 1'b1;
            end else if (ph_e == PH_FIRST) begin
                n_h1 = i_in_byte;
            end else if (ph_e == PH_SECOND) begin
                n_h2 = i_in_byte;
            end else begin
                push.num = 2'd3;
                if (r_mode == MODE_ENC) begin
                    push.ent[0] = '{data: eg,      last: 1'b0};
                    push.ent[1] = '{data: eg - er, last: 1'b0};
                    push.ent[2] = '{data: eg - eb, last: 1'b1};
                    if (det_e) begin
                        n_run = enc_run;
                        n_det = enc_run != '0;
                    end
                end else begin
                    push.ent[0] = '{data: cb, last: 1'b0};
                    push.ent[1] = '{data: cg, last: 1'b0};
                    push.ent[2] = '{data: cr, last: 1'b1};
                    if (det_e) begin
                        n_run = dec_run;
                        n_det = dec_run != '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_ENC;
            r_row_bytes <= ROW_RESET;
            r_min_run   <= MIN_RUN_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_MODE:    r_mode      <= i_cfg_data[0];
                CFG_ROW:     r_row_bytes <= i_cfg_data;
                CFG_MIN_RUN: r_min_run   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_phase <= PH_FIRST;
            r_h1    <= '0;
            r_h2    <= '0;
            r_run   <= '0;
            r_det   <= 1'b1;
        end else begin
            r_pos   <= n_pos;
            r_phase <= n_phase;
            r_h1    <= n_h1;
            r_h2    <= n_h2;
            r_run   <= n_run;
            r_det   <= n_det;
        end
    end

    assign pop = o_out_valid && i_out_ready;

    rcd_outq #(
        .DEPTH (DEPTH)
    ) u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_head  (head),
        .o_count (q_count)
    );

    assign o_in_ready    = q_count <= CW'(DEPTH - 3);
    assign o_out_valid   = q_count != '0;
    assign o_out_byte    = head.data;
    assign o_last_of_run = head.last;

    `RCD_ASSERT_IMPL(a_queue_bound, 1'b1, q_count <= CW'(DEPTH))
    `RCD_ASSERT_NEXT(a_pixel_out, acc && pix3, o_out_valid)
    `RCD_ASSERT_NEXT(a_det_hold, !(acc && (pix3 || i_start_of_image)), $stable(r_det))
    `RCD_ASSERT_NEXT(a_det_run, acc && pix3 && det_e, r_det == (r_run != '0))
    `RCD_ASSERT_NEXT(a_det_sticky, !r_det && !(acc && i_start_of_image), !r_det)

endmodule

/* test/rgb_color_decorrelate_filter_test.sv */
// Self-checking testbench for the green-difference color filter: directed and random byte streams.
`timescale 1ns / 1ps

module rgb_color_decorrelate_filter_test;
    import rcd_pkg::*;

    localparam logic [1:0] CFG_NONE = 2'd3;
    localparam int HOLD_CYCLES = 80;
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        logic        mode;
        logic [15:0] row_len;
        logic [15:0] run_min;
        logic [15:0] pos;
        logic [7:0]  first;
        logic [7:0]  second;
        logic [15:0] run;
        logic        detecting;
    } t_filt;

    typedef struct packed {
        logic [7:0] data;
        logic       sof;
    } t_word;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  in_byte;
    logic        in_sof;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  out_byte;
    logic        out_last;

    t_filt pixel_state;
    t_res  expected_bytes[$];
    int    errors;
    int    burst_left;
    bit    gaps_on;
    bit    hold_req;

    rgb_color_decorrelate_filter DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (cfg_wr_en),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_in_byte        (in_byte),
        .i_start_of_image (in_sof),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_out_byte       (out_byte),
        .o_last_of_run    (out_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic logic like_565(logic [7:0] b, logic [7:0] g, logic [7:0] r);
        return (b[2:0] == {3{b[3]}}) && (g[1:0] == {2{g[2]}}) && (r[2:0] == {3{r[3]}});
    endfunction

    function automatic logic [15:0] bump_run(logic [15:0] run, logic hit);
        if (!hit) return 16'd0;
        return (run == RUN_SAT) ? RUN_SAT : run + 16'd1;
    endfunction

    function automatic logic [23:0] toggle_565(logic [7:0] b, logic [7:0] g, logic [7:0] r);
        return {b ^ {5'd0, {3{b[3]}}}, g ^ {6'd0, {2{g[2]}}}, r ^ {5'd0, {3{r[3]}}}};
    endfunction

    function automatic void filt_step(inout t_filt s, input logic [7:0] din, input logic sof,
                                      output t_push res);
        logic [15:0] limit;
        logic [15:0] prev;
        logic [16:0] nxt;
        logic [7:0]  b;
        logic [7:0]  g;
        logic [7:0]  r;
        if (sof) begin
            s.pos = 16'd0;
            s.first = 8'd0;
            s.second = 8'd0;
            s.run = 16'd0;
            s.detecting = 1'b1;
        end
        limit = (s.row_len / 16'd3) * 16'd3;
        res = '0;
        if (s.pos < limit) begin
            case (s.pos % 16'd3)
                PH_FIRST: s.first = din;
                PH_SECOND: s.second = din;
                default: begin
                    if (s.mode == MODE_ENC) begin
                        b = s.first;
                        g = s.second;
                        r = din;
                        if (s.detecting) begin
                            prev = s.run;
                            s.run = bump_run(s.run, like_565(b, g, r));
                            if (s.run > s.run_min || prev >= s.run_min)
                                {b, g, r} = toggle_565(b, g, r);
                            s.detecting = (s.run != 16'd0);
                        end
                        res.ent[0].data = g;
                        res.ent[1].data = g - r;
                        res.ent[2].data = g - b;
                    end else begin
                        g = s.first;
                        r = g - s.second;
                        b = g - din;
                        if (s.detecting) begin
                            if (s.run >= s.run_min) {b, g, r} = toggle_565(b, g, r);
                            s.run = bump_run(s.run, like_565(b, g, r));
                            s.detecting = (s.run != 16'd0);
                        end
                        res.ent[0].data = b;
                        res.ent[1].data = g;
                        res.ent[2].data = r;
                    end
                    res.ent[2].last = 1'b1;
                    res.num = 2'd3;
                end
            endcase
        end else begin
            res.ent[0].data = din;
            res.ent[0].last = 1'b1;
            res.num = 2'd1;
        end
        nxt = s.pos + 17'd1;
        s.pos = (nxt >= {1'b0, s.row_len}) ? 16'd0 : nxt[15:0];
    endfunction

    // receiver: random stall pattern in stretches, plus a long hold-off on request
    initial begin
        int stretch;
        int stall_pct;
        stretch = 0;
        stall_pct = 0;
        out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end
            if (stretch == 0) begin
                stretch = $urandom_range(20, 60);
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 25;
                    2: stall_pct = 50;
                    default: stall_pct = 85;
                endcase
            end
            stretch--;
            out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && out_valid && out_ready) begin
            if (expected_bytes.size() == 0) begin
                $display("%0t: out_byte expected none got %02h last %0b", $time, out_byte,
                         out_last);
                errors++;
            end else begin
                want = expected_bytes.pop_front();
                if (out_byte !== want.data) begin
                    $display("%0t: out_byte expected %02h got %02h", $time, want.data, out_byte);
                    errors++;
                end
                if (out_last !== want.last) begin
                    $display("%0t: last_of_run expected %0b got %0b", $time, want.last, out_last);
                    errors++;
                end
            end
        end
    end

    task automatic send_word(input logic [7:0] data, input logic sof);
        t_push res;
        int gap;
        if (gaps_on && burst_left == 0) begin
            gap = $urandom_range(1, 6);
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
            burst_left = $urandom_range(1, 24);
        end
        if (burst_left > 0) burst_left--;
        in_valid <= 1'b1;
        in_byte <= data;
        in_sof <= sof;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        filt_step(pixel_state, data, sof, res);
        for (int k = 0; k < res.num; k++) expected_bytes.push_back(res.ent[k]);
        @(negedge i_clk);
    endtask

    task automatic wait_drained;
        in_valid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [1:0] index, input logic [15:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        @(negedge i_clk);
        cfg_wr_en <= 1'b0;
        case (index)
            CFG_MODE: pixel_state.mode = data[0];
            CFG_ROW: pixel_state.row_len = data;
            CFG_MIN_RUN: pixel_state.run_min = data;
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // mostly RGB565-looking pixels; in decode mode feed the encoded form of them
    task automatic send_random(input int count);
        t_word       pending[$];
        t_word       w;
        t_filt       twin;
        t_push       tres;
        logic [7:0]  v;
        logic [15:0] p;
        logic [15:0] lim;
        logic        sof;
        logic        carry;
        logic        broken;
        int          sent;
        twin = pixel_state;
        twin.mode = MODE_ENC;
        carry = 1'b0;
        broken = 1'b0;
        sent = 0;
        while (sent < count || pending.size() != 0) begin
            if (pending.size() == 0) begin
                sof = ($urandom_range(0, 99) < 3);
                p = sof ? 16'd0 : twin.pos;
                lim = (twin.row_len / 16'd3) * 16'd3;
                v = 8'($urandom_range(0, 255));
                if (p < lim) begin
                    case (p % 16'd3)
                        PH_FIRST: begin
                            broken = ($urandom_range(0, 99) < 10);
                            if (!broken) v[2:0] = {3{v[3]}};
                        end
                        PH_SECOND: if (!broken) v[1:0] = {2{v[2]}};
                        default: if (!broken) v[2:0] = {3{v[3]}};
                    endcase
                end
                filt_step(twin, v, sof, tres);
                if (pixel_state.mode == MODE_ENC) begin
                    pending.push_back({v, sof});
                end else begin
                    carry = carry | sof;
                    for (int k = 0; k < tres.num; k++) begin
                        pending.push_back({tres.ent[k].data, carry});
                        carry = 1'b0;
                    end
                end
            end
            if (pending.size() != 0) begin
                w = pending.pop_front();
                send_word(w.data, w.sof);
                sent++;
            end
        end
    endtask

    task automatic test_reset_defaults;
        send_word(8'h00, 1'b1);
        send_word(8'hFF, 1'b0);
        send_word(8'h80, 1'b0);
    endtask

    task automatic test_min_run_zero;
        wait_drained();
        cfg_write(CFG_ROW, 16'd4);
        cfg_write(CFG_MIN_RUN, 16'd0);
        send_word(8'h0F, 1'b1);
        send_word(8'h07, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'hAA, 1'b0);
        send_word(8'h01, 1'b0);
        send_word(8'h02, 1'b0);
        send_word(8'h03, 1'b0);
        send_word(8'h55, 1'b0);
    endtask

    task automatic test_decode_mid_pixel;
        wait_drained();
        cfg_write(CFG_MODE, 16'(MODE_DEC));
        send_word(8'h11, 1'b1);
        send_word(8'h22, 1'b0);
        send_word(8'h33, 1'b0);
        send_word(8'h44, 1'b0);
        send_word(8'h10, 1'b0);
        wait_drained();
        cfg_write(CFG_MODE, 16'(MODE_ENC));
        send_word(8'h20, 1'b0);
        send_word(8'h30, 1'b0);
    endtask

    task automatic test_row_limits;
        wait_drained();
        cfg_write(CFG_ROW, 16'd0);
        send_word(8'hC3, 1'b0);
        wait_drained();
        cfg_write(CFG_ROW, 16'd8);
        send_word(8'h08, 1'b1);
        send_word(8'h04, 1'b0);
        send_word(8'h08, 1'b0);
        send_word(8'hF0, 1'b0);
        send_word(8'h0C, 1'b0);
        wait_drained();
        cfg_write(CFG_ROW, 16'd2);
        send_word(8'h99, 1'b0);
        wait_drained();
        cfg_write(CFG_NONE, 16'hFFFF);
        cfg_write(CFG_ROW, 16'd1);
        send_word(8'h5A, 1'b0);
    endtask

    task automatic test_random_settings;
        for (int ph = 0; ph < 7; ph++) begin
            wait_drained();
            case (ph)
                0: begin
                    cfg_write(CFG_MODE, 16'(MODE_ENC));
                    cfg_write(CFG_ROW, 16'd12);
                    cfg_write(CFG_MIN_RUN, 16'd2);
                end
                1: cfg_write(CFG_MODE, 16'(MODE_DEC));
                2: begin
                    cfg_write(CFG_MODE, 16'(MODE_ENC));
                    cfg_write(CFG_ROW, 16'hFFFF);
                    cfg_write(CFG_MIN_RUN, 16'd0);
                end
                3: begin
                    cfg_write(CFG_MODE, 16'(MODE_DEC));
                    cfg_write(CFG_ROW, 16'd7);
                    cfg_write(CFG_MIN_RUN, 16'd5);
                end
                4: begin
                    cfg_write(CFG_MODE, 16'(MODE_ENC));
                    cfg_write(CFG_ROW, 16'($urandom_range(1, 30)));
                    cfg_write(CFG_MIN_RUN, 16'hFFFF);
                end
                5: begin
                    cfg_write(CFG_MODE, 16'(MODE_DEC));
                    cfg_write(CFG_ROW, 16'hFFFF);
                    cfg_write(CFG_MIN_RUN, 16'($urandom_range(0, 8)));
                end
                default: begin
                    cfg_write(CFG_MODE, 16'($urandom_range(0, 1)));
                    cfg_write(CFG_ROW, 16'($urandom_range(3, 20)));
                    cfg_write(CFG_MIN_RUN, 16'($urandom_range(0, 4)));
                end
            endcase
            send_random(30);
        end
    endtask

    task automatic test_backpressure;
        wait_drained();
        cfg_write(CFG_MODE, 16'(MODE_ENC));
        cfg_write(CFG_ROW, 16'd9);
        cfg_write(CFG_MIN_RUN, 16'd1);
        gaps_on = 1'b0;
        hold_req = 1'b1;
        send_random(30);
        gaps_on = 1'b1;
    endtask

    initial begin
        i_rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_MODE;
        cfg_data = 16'd0;
        in_valid = 1'b0;
        in_byte = 8'd0;
        in_sof = 1'b0;
        errors = 0;
        burst_left = 0;
        gaps_on = 1'b1;
        hold_req = 1'b0;
        pixel_state = '0;
        pixel_state.mode = MODE_ENC;
        pixel_state.row_len = ROW_RESET;
        pixel_state.run_min = MIN_RUN_RESET;
        pixel_state.detecting = 1'b1;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_defaults();
        test_min_run_zero();
        test_decode_mid_pixel();
        test_row_limits();
        test_random_settings();
        test_backpressure();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0 && expected_bytes.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl
rtl/rcd_pkg.sv
rtl/rcd_outq.sv
rtl/rgb_color_decorrelate_filter.sv
test/rgb_color_decorrelate_filter_test.sv
